// ===== rtl/core/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants of the 3x3 Laplacian sharpening filter.
// ----------------------------------------------------------------------------
package lsh_pkg;

  typedef logic [31:0] pix_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned KERNEL_W   = 45;
  localparam int unsigned IMG_W_W    = 12;
  localparam int unsigned IMG_H_W    = 13;
  localparam int unsigned COL_W      = 11;
  localparam int unsigned ROW_W      = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [KERNEL_W-1:0] KERNEL_RST = 45'd1066197287904;
  localparam logic [IMG_W_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [IMG_H_W-1:0]  HEIGHT_RST = 13'd480;
  localparam logic [IMG_H_W-1:0]  MAX_HEIGHT = 13'd4096;
  localparam logic [7:0]          PIX_MAX    = 8'd255;

  // column request handed from the line buffer to the window stage
  typedef struct packed {
    pix_t             far_pix;
    pix_t             near_pix;
    pix_t             cur_pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             c_ge1;
    logic             c_ge2;
    logic             r_ge1;
    logic             r_ge2;
    logic             last_col;
    logic             last_row;
  } col_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } res_t;

endpackage

// ===== rtl/core/lsh_pix_if.sv =====
// ----------------------------------------------------------------------------
// lsh_pix_if
// Pixel request channel: valid/ready plus one RGBA pixel.
// ----------------------------------------------------------------------------
interface lsh_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// ===== rtl/core/lsh_res_if.sv =====
// ----------------------------------------------------------------------------
// lsh_res_if
// Result request channel: valid/ready plus one sharpened pixel.
// ----------------------------------------------------------------------------
interface lsh_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [7:0]  alpha_out;
  logic [10:0] out_col;
  logic [11:0] out_row;
  logic        last_of_run;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, out_col, out_row,
                  last_of_run, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, out_col, out_row,
                  last_of_run, output ready);
endinterface

// ===== rtl/core/lsh_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lsh_cfg_if
// Configuration write channel: valid/ready, register index and data.
// ----------------------------------------------------------------------------
interface lsh_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [44:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lsh_line_buf.sv =====
// ----------------------------------------------------------------------------
// lsh_line_buf
// Raster counters, two row stores and the input register stage.
// ----------------------------------------------------------------------------
module lsh_line_buf #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lsh_pkg::pix_t                 in_pix,
  input  logic [lsh_pkg::IMG_W_W-1:0]   image_width,
  input  logic [lsh_pkg::IMG_H_W-1:0]   image_height,
  input  logic                          adv_ok,
  output logic                          s1_valid,
  output lsh_pkg::col_t                 s1_col
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EW = ((CW > lsh_pkg::IMG_W_W) ? CW : lsh_pkg::IMG_W_W) + 1;

  logic [31:0] near_mem [MAX_WIDTH];
  logic [31:0] far_mem  [MAX_WIDTH];

  logic [CW-1:0]             c_r, c_nxt;
  logic [lsh_pkg::ROW_W-1:0] r_r, r_nxt;
  logic                      s1_valid_r, s1_valid_nxt;
  logic [CW-1:0]             s1_c_r;
  lsh_pkg::pix_t             cur_r, near_rd_r, far_rd_r, fwd_data_r;
  logic                      fwd_r;
  logic [lsh_pkg::ROW_W-1:0] s1_row_r;
  logic                      last_col_r, last_row_r;

  logic [EW-1:0]              w_eff;
  logic [lsh_pkg::IMG_H_W-1:0] h_eff;
  logic                       last_col, last_row, accept, adv;

  always_comb begin
    w_eff = EW'(image_width);
    if (w_eff == '0) w_eff = EW'(1);
    if (w_eff > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    h_eff = image_height;
    if (h_eff == '0) h_eff = lsh_pkg::IMG_H_W'(1);
    if (h_eff > lsh_pkg::MAX_HEIGHT) h_eff = lsh_pkg::MAX_HEIGHT;
  end

  assign adv      = s1_valid_r && adv_ok;
  assign in_ready = !s1_valid_r || adv_ok;
  assign accept   = in_valid && in_ready;
  assign last_col = (EW'(c_r) + EW'(1)) >= w_eff;
  assign last_row = ({1'b0, r_r} + lsh_pkg::IMG_H_W'(1)) >= h_eff;

  always_comb begin
    c_nxt = c_r;
    r_nxt = r_r;
    if (accept) begin
      if (last_col) begin
        c_nxt = '0;
        r_nxt = last_row ? '0 : r_r + 1'b1;
      end else begin
        c_nxt = c_r + 1'b1;
      end
    end
    s1_valid_nxt = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r        <= '0;
      r_r        <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      c_r        <= c_nxt;
      r_r        <= r_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      near_mem[c_r] <= in_pix;
      near_rd_r     <= near_mem[c_r];
      far_rd_r      <= far_mem[c_r];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      far_mem[s1_c_r] <= near_rd_r;
    end
  end

  // far write of the item leaving now lands after the new read: bypass it
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_r      <= adv && (s1_c_r == c_r);
      fwd_data_r <= near_rd_r;
      cur_r      <= in_pix;
      s1_c_r     <= c_r;
      s1_row_r   <= r_r;
      last_col_r <= last_col;
      last_row_r <= last_row;
    end
  end

  always_comb begin
    s1_col.far_pix  = fwd_r ? fwd_data_r : far_rd_r;
    s1_col.near_pix = near_rd_r;
    s1_col.cur_pix  = cur_r;
    s1_col.col      = lsh_pkg::COL_W'(s1_c_r);
    s1_col.row      = s1_row_r;
    s1_col.c_ge1    = (s1_c_r != '0);
    s1_col.c_ge2    = (s1_c_r > CW'(1));
    s1_col.r_ge1    = (s1_row_r != '0);
    s1_col.r_ge2    = (s1_row_r > lsh_pkg::ROW_W'(1));
    s1_col.last_col = last_col_r;
    s1_col.last_row = last_row_r;
  end

  assign s1_valid = s1_valid_r;

endmodule

// ===== rtl/core/lsh_kernel.sv =====
// ----------------------------------------------------------------------------
// lsh_kernel
// Tap selection with edge replication, 3x3 weighted sum and clamp.
// ----------------------------------------------------------------------------
module lsh_kernel #(
  parameter int unsigned WEIGHT_BITS = 5
) (
  input  lsh_pkg::pix_t              win [9],
  input  lsh_pkg::col_t              info,
  input  logic [1:0]                 sel,
  input  logic                       last,
  input  logic [9*WEIGHT_BITS-1:0]   weights,
  output lsh_pkg::res_t              res
);

  localparam int unsigned ACC_W = WEIGHT_BITS + 14;

  logic [1:0]              ri [3];
  logic [1:0]              ci [3];
  logic signed [ACC_W-1:0] acc [3];
  logic signed [ACC_W-1:0] tot [3];
  lsh_pkg::pix_t           ctr;
  lsh_pkg::pix_t           p;
  logic signed [WEIGHT_BITS-1:0] w;
  logic [7:0]              ch_out [3];

  always_comb begin
    // sel[1]: last-row pass, sel[0]: last-column pass
    if (!sel[1]) begin
      ri[0] = info.r_ge2 ? 2'd0 : 2'd1; ri[1] = 2'd1; ri[2] = 2'd2;
    end else begin
      ri[0] = info.r_ge1 ? 2'd1 : 2'd2; ri[1] = 2'd2; ri[2] = 2'd2;
    end
    if (!sel[0]) begin
      ci[0] = info.c_ge2 ? 2'd0 : 2'd1; ci[1] = 2'd1; ci[2] = 2'd2;
    end else begin
      ci[0] = info.c_ge1 ? 2'd1 : 2'd2; ci[1] = 2'd2; ci[2] = 2'd2;
    end
  end

  always_comb begin
    ctr = win[4'(ri[1] * 3 + ci[1])];
    for (int ch = 0; ch < 3; ch++) acc[ch] = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p = win[4'(ri[i] * 3 + ci[j])];
        w = weights[(i*3+j)*WEIGHT_BITS +: WEIGHT_BITS];
        for (int ch = 0; ch < 3; ch++) begin
          acc[ch] = acc[ch] + ACC_W'($signed({1'b0, p[8*ch +: 8]}) * w);
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = acc[ch] + $signed(ACC_W'(ctr[8*ch +: 8]));
      if (tot[ch] < 0)                          ch_out[ch] = '0;
      else if (tot[ch] > $signed(ACC_W'(lsh_pkg::PIX_MAX))) ch_out[ch] = lsh_pkg::PIX_MAX;
      else                                      ch_out[ch] = tot[ch][7:0];
    end
  end

  always_comb begin
    res.red   = ch_out[0];
    res.green = ch_out[1];
    res.blue  = ch_out[2];
    res.alpha = ctr[31:24];
    res.col   = sel[0] ? info.col : info.col - 1'b1;
    res.row   = sel[1] ? info.row : info.row - 1'b1;
    res.last  = last;
  end

endmodule

// ===== rtl/core/laplacian_sharpen_3x3.sv =====
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// 3x3 Laplacian sharpening of an RGBA raster stream with edge replication.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix  : RGBA pixels in raster order, one request per pixel.
//   out_res : sharpened pixels with their column/row; last_of_run marks the
//             final result caused by one input pixel (0 to 4 results each).
//   cfg_wr  : register writes (0 kernel weights, 1 width, 2 height), always
//             ready; write only while the block is idle.
// Path: a result reaches out_res from the pixel that completes it through the
//   input register, which loads when that pixel is accepted, then the window
//   register, then the output register.
// Throughput: one pixel per cycle while each pixel causes at most one result
//   and out_res is not held; a pixel causing n results holds the window stage
//   until all n are out, as the single result port takes one result per cycle.
// Reset: counters restart at column 0, row 0; registers take their defaults
//   (4-neighbour kernel, 640x480). Row stores are not cleared.
// Stall: a held out_res keeps its result; the window stage and input
//   register fill behind it, then in_pix.ready drops.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3 #(
  parameter int unsigned MAX_WIDTH   = 2048,
  parameter int unsigned WEIGHT_BITS = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  lsh_pix_if.sink      in_pix,
  lsh_res_if.source    out_res,
  lsh_cfg_if.sink      cfg_wr
);

  localparam int unsigned WV_W = 9 * WEIGHT_BITS;

  logic [lsh_pkg::KERNEL_W-1:0] kernel_r;
  logic [lsh_pkg::IMG_W_W-1:0]  width_r;
  logic [lsh_pkg::IMG_H_W-1:0]  height_r;

  logic [WV_W + lsh_pkg::KERNEL_W - 1:0] kern_ext;
  logic [WV_W-1:0]                       weights;

  lsh_pkg::pix_t  in_data;
  logic           s1_valid, s2_take, s1_adv;
  lsh_pkg::col_t  s1_col, s2_info_r;
  lsh_pkg::pix_t  win_r [9];
  logic [3:0]     mask_r, mask_nxt, pick, rest;
  logic [1:0]     sel;
  logic           emit, last, out_free;
  lsh_pkg::res_t  res, out_r;
  logic           out_valid_r;

  // configuration
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= lsh_pkg::KERNEL_RST;
      width_r  <= lsh_pkg::WIDTH_RST;
      height_r <= lsh_pkg::HEIGHT_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        lsh_pkg::CFG_KERNEL: kernel_r <= cfg_wr.data;
        lsh_pkg::CFG_WIDTH:  width_r  <= cfg_wr.data[lsh_pkg::IMG_W_W-1:0];
        lsh_pkg::CFG_HEIGHT: height_r <= cfg_wr.data[lsh_pkg::IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  assign kern_ext = {{WV_W{1'b0}}, kernel_r};
  assign weights  = kern_ext[WV_W-1:0];

  // input register and line stores
  assign in_data = {in_pix.alpha_in, in_pix.blue_in, in_pix.green_in, in_pix.red_in};

  lsh_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_pix.valid),
    .in_ready     (in_pix.ready),
    .in_pix       (in_data),
    .image_width  (width_r),
    .image_height (height_r),
    .adv_ok       (s2_take),
    .s1_valid     (s1_valid),
    .s1_col       (s1_col)
  );

  // window stage: one result per cycle from the pending mask when out_free
  assign out_free = !out_valid_r || out_res.ready;
  assign pick     = mask_r & (~mask_r + 4'd1);
  assign rest     = mask_r & ~pick;
  assign emit     = (mask_r != '0) && out_free;
  assign last     = (rest == '0);
  assign s2_take  = (mask_r == '0) || (emit && last);
  assign s1_adv   = s1_valid && s2_take;

  always_comb begin
    case (pick)
      4'b0001: sel = 2'd0;
      4'b0010: sel = 2'd1;
      4'b0100: sel = 2'd2;
      4'b1000: sel = 2'd3;
      default: sel = 2'd0;
    endcase
  end

  always_comb begin
    mask_nxt = mask_r;
    if (s1_adv) begin
      mask_nxt = {s1_col.last_row & s1_col.last_col,
                  s1_col.last_row & s1_col.c_ge1,
                  s1_col.r_ge1 & s1_col.last_col,
                  s1_col.r_ge1 & s1_col.c_ge1};
    end else if (emit) begin
      mask_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else begin
      mask_r <= mask_nxt;
      if (s1_adv) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i*3]   <= win_r[i*3+1];
          win_r[i*3+1] <= win_r[i*3+2];
        end
        win_r[2] <= s1_col.far_pix;
        win_r[5] <= s1_col.near_pix;
        win_r[8] <= s1_col.cur_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) s2_info_r <= s1_col;
  end

  lsh_kernel #(.WEIGHT_BITS(WEIGHT_BITS)) u_kernel (
    .win     (win_r),
    .info    (s2_info_r),
    .sel     (sel),
    .last    (last),
    .weights (weights),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= res;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.red_out     = out_r.red;
  assign out_res.green_out   = out_r.green;
  assign out_res.blue_out    = out_r.blue;
  assign out_res.alpha_out   = out_r.alpha;
  assign out_res.out_col     = out_r.col;
  assign out_res.out_row     = out_r.row;
  assign out_res.last_of_run = out_r.last;

  a_mask_progress: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !last |=> mask_r != '0)
    else $error("pending results lost after a non-final result");

  a_adv_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |-> (mask_r == '0) || (emit && last))
    else $error("window advanced with results pending");

  a_input_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready && s1_valid |-> s1_adv)
    else $error("input register overwritten");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> last || ($countones(mask_r) > 1))
    else $error("last_of_run flag inconsistent with pending mask");

endmodule
